/* hdl/ipid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

    // field and register widths
    localparam int IN_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // error history and difference widths
    localparam int ERR_W  = IN_W + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 2;
    localparam int PROD_W = GAIN_W + 1 + D2_W;

    // default fraction width of the gains
    localparam int FRAC_BITS_DEF = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN     = 3'd0,
        REG_KI_GAIN     = 3'd1,
        REG_KD_GAIN     = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_DRIVE_UPPER = 3'd4,
        REG_DRIVE_LOWER = 3'd5
    } reg_idx_t;

    // register values after reset
    localparam logic [GAIN_W-1:0]         KP_RESET    = 16'd12800;
    localparam logic [GAIN_W-1:0]         KI_RESET    = 16'd128;
    localparam logic [GAIN_W-1:0]         KD_RESET    = 16'd5120;
    localparam logic [GAIN_W-1:0]         BAND_RESET  = 16'd26;
    localparam logic signed [DRIVE_W-1:0] UPPER_RESET = 24'sd1048320;
    localparam logic signed [DRIVE_W-1:0] LOWER_RESET = 24'sd0;

    // control flags handed from the error stage to the output stage
    typedef struct packed {
        logic clear;
        logic held;
    } stage_ctl_t;

endpackage

`default_nettype wire

/* hdl/ipid_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipid_front #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        in_valid,
    output logic                                             in_stall,
    input  wire logic                                        func,
    input  wire logic signed [ipid_pkg::IN_W-1:0]            target,
    input  wire logic signed [ipid_pkg::IN_W-1:0]            measured_value,
    input  wire logic [ipid_pkg::GAIN_W-1:0]                 kp_gain,
    input  wire logic [ipid_pkg::GAIN_W-1:0]                 ki_gain,
    input  wire logic [ipid_pkg::GAIN_W-1:0]                 kd_gain,
    input  wire logic [ipid_pkg::GAIN_W-1:0]                 dead_band,
    output logic                                             mid_valid,
    input  wire logic                                        mid_ready,
    output ipid_pkg::stage_ctl_t                             mid_ctl,
    output logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0]     term_p,
    output logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0]     term_i,
    output logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0]     term_d
);

    localparam int TERM_W = ipid_pkg::PROD_W - FRAC_BITS;

    logic                                  in_valid_reg;
    logic                                  func_reg;
    logic signed [ipid_pkg::IN_W-1:0]      target_reg;
    logic signed [ipid_pkg::IN_W-1:0]      measured_reg;
    logic signed [ipid_pkg::ERR_W-1:0]     err_last_reg;
    logic signed [ipid_pkg::ERR_W-1:0]     err_older_reg;
    logic                                  mid_valid_reg;
    ipid_pkg::stage_ctl_t                  mid_ctl_reg;
    logic signed [TERM_W-1:0]              term_p_reg;
    logic signed [TERM_W-1:0]              term_i_reg;
    logic signed [TERM_W-1:0]              term_d_reg;

    logic                                  mid_free;
    logic                                  in_free;
    logic                                  in_take;
    logic                                  step;
    logic signed [ipid_pkg::ERR_W-1:0]     error;
    logic [ipid_pkg::ERR_W-1:0]            mag_full;
    logic                                  in_band;
    logic signed [ipid_pkg::D1_W-1:0]      diff1;
    logic signed [ipid_pkg::D2_W-1:0]      diff2;
    logic signed [ipid_pkg::PROD_W-1:0]    prod_p;
    logic signed [ipid_pkg::PROD_W-1:0]    prod_i;
    logic signed [ipid_pkg::PROD_W-1:0]    prod_d;

    // stage flow control
    assign mid_free = !mid_valid_reg || mid_ready;
    assign in_free  = !in_valid_reg || mid_free;
    assign in_stall = !in_free;
    assign in_take  = in_valid && in_free;
    assign step     = in_valid_reg && mid_free;

    // error and dead zone test
    assign error    = {target_reg[ipid_pkg::IN_W-1], target_reg}
                    - {measured_reg[ipid_pkg::IN_W-1], measured_reg};
    assign mag_full = error[ipid_pkg::ERR_W-1] ? -error : error;
    assign in_band  = mag_full[ipid_pkg::IN_W-1:0] < dead_band;

    // first and second differences of the error
    assign diff1 = ipid_pkg::D1_W'(error) - ipid_pkg::D1_W'(err_last_reg);
    assign diff2 = ipid_pkg::D2_W'(error) - (ipid_pkg::D2_W'(err_last_reg) <<< 1)
                 + ipid_pkg::D2_W'(err_older_reg);

    // gain products, each floored to the output fraction
    assign prod_p = $signed({1'b0, kp_gain}) * diff1;
    assign prod_i = $signed({1'b0, ki_gain}) * error;
    assign prod_d = $signed({1'b0, kd_gain}) * diff2;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg     <= func;
            target_reg   <= target;
            measured_reg <= measured_value;
        end
    end

    // error history, moves only on an adjusting step and is zeroed by a clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_last_reg  <= '0;
            err_older_reg <= '0;
        end
        else if (step)
        begin
            if (func_reg)
            begin
                err_last_reg  <= '0;
                err_older_reg <= '0;
            end
            else if (!in_band)
            begin
                err_older_reg <= err_last_reg;
                err_last_reg  <= error;
            end
        end
    end

    // stage register towards the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_free)
        begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mid_ctl_reg.clear <= func_reg;
            mid_ctl_reg.held  <= in_band;
            term_p_reg        <= TERM_W'(prod_p >>> FRAC_BITS);
            term_i_reg        <= TERM_W'(prod_i >>> FRAC_BITS);
            term_d_reg        <= TERM_W'(prod_d >>> FRAC_BITS);
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_ctl   = mid_ctl_reg;
    assign term_p    = term_p_reg;
    assign term_i    = term_i_reg;
    assign term_d    = term_d_reg;

endmodule

`default_nettype wire

/* hdl/ipid_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipid_back #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        mid_valid,
    output logic                                             mid_ready,
    input  wire ipid_pkg::stage_ctl_t                        mid_ctl,
    input  wire logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0] term_p,
    input  wire logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0] term_i,
    input  wire logic signed [ipid_pkg::PROD_W-FRAC_BITS-1:0] term_d,
    input  wire logic signed [ipid_pkg::DRIVE_W-1:0]         drive_upper,
    input  wire logic signed [ipid_pkg::DRIVE_W-1:0]         drive_lower,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic signed [ipid_pkg::DRIVE_W-1:0]              drive,
    output logic                                             held
);

    localparam int TERM_W  = ipid_pkg::PROD_W - FRAC_BITS;
    localparam int DELTA_W = TERM_W + 2;
    localparam int SUM_W   = ((DELTA_W > ipid_pkg::DRIVE_W) ? DELTA_W : ipid_pkg::DRIVE_W) + 1;

    logic signed [ipid_pkg::DRIVE_W-1:0] drive_level_reg;
    logic                                out_valid_reg;
    logic signed [ipid_pkg::DRIVE_W-1:0] drive_reg;
    logic                                held_reg;

    logic                                fire;
    logic signed [SUM_W-1:0]             delta;
    logic signed [SUM_W-1:0]             sum;
    logic signed [ipid_pkg::DRIVE_W-1:0] clamped;

    // output register flow control
    assign mid_ready = !out_valid_reg || !out_stall;
    assign fire      = mid_valid && mid_ready;

    // increment, new level and clamp (upper limit tested first when limits cross)
    assign delta = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
    assign sum   = delta + SUM_W'(drive_level_reg);

    always_comb
    begin
        if (sum > SUM_W'(drive_upper))
        begin
            clamped = drive_upper;
        end
        else if (sum < SUM_W'(drive_lower))
        begin
            clamped = drive_lower;
        end
        else
        begin
            clamped = ipid_pkg::DRIVE_W'(sum);
        end
    end

    // held output level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_level_reg <= '0;
        end
        else if (fire)
        begin
            if (mid_ctl.clear)
            begin
                drive_level_reg <= '0;
            end
            else if (!mid_ctl.held)
            begin
                drive_level_reg <= clamped;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (mid_ctl.clear)
            begin
                drive_reg <= '0;
                held_reg  <= 1'b0;
            end
            else if (mid_ctl.held)
            begin
                drive_reg <= drive_level_reg;
                held_reg  <= 1'b1;
            end
            else
            begin
                drive_reg <= clamped;
                held_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign held      = held_reg;

endmodule

`default_nettype wire

/* hdl/incremental_pid_deadzone.sv */
`timescale 1ns / 1ps
`default_nettype none

// Incremental PID regulator with a dead zone, Q8.8 gains and errors, Q16.8 output.
// A compute transaction forms e = target - measured_value; if |e| is below dead_band the
// held drive comes back with held set and nothing changes, otherwise the increment
// kp*(e-e1) + ki*e + kd*(e-2e1+e2), each product floored by FRAC_BITS, is added to the
// drive and clamped to drive_upper (tested first) and drive_lower. A clear transaction
// zeroes history and drive. One transaction is taken every clock while neither side
// stalls: the input register is loaded at acceptance, then the error and product stage
// register (which also updates the error history), and the sum and clamp stage then
// loads the result register. Configuration is written through cfg_wr_en, cfg_index and
// cfg_data while idle; the user keeps to this, the block itself does not enforce it.

module incremental_pid_deadzone #(
    parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ipid_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic signed [ipid_pkg::IN_W-1:0]    target,
    input  wire logic signed [ipid_pkg::IN_W-1:0]    measured_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [ipid_pkg::DRIVE_W-1:0]      drive,
    output logic                                     held
);

    localparam int TERM_W = ipid_pkg::PROD_W - FRAC_BITS;

    logic [ipid_pkg::GAIN_W-1:0]         kp_gain_reg;
    logic [ipid_pkg::GAIN_W-1:0]         ki_gain_reg;
    logic [ipid_pkg::GAIN_W-1:0]         kd_gain_reg;
    logic [ipid_pkg::GAIN_W-1:0]         dead_band_reg;
    logic signed [ipid_pkg::DRIVE_W-1:0] drive_upper_reg;
    logic signed [ipid_pkg::DRIVE_W-1:0] drive_lower_reg;

    logic                                mid_valid;
    logic                                mid_ready;
    ipid_pkg::stage_ctl_t                mid_ctl;
    logic signed [TERM_W-1:0]            term_p;
    logic signed [TERM_W-1:0]            term_i;
    logic signed [TERM_W-1:0]            term_d;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg     <= ipid_pkg::KP_RESET;
            ki_gain_reg     <= ipid_pkg::KI_RESET;
            kd_gain_reg     <= ipid_pkg::KD_RESET;
            dead_band_reg   <= ipid_pkg::BAND_RESET;
            drive_upper_reg <= ipid_pkg::UPPER_RESET;
            drive_lower_reg <= ipid_pkg::LOWER_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (ipid_pkg::reg_idx_t'(cfg_index))
                ipid_pkg::REG_KP_GAIN:     kp_gain_reg     <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_KI_GAIN:     ki_gain_reg     <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_KD_GAIN:     kd_gain_reg     <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_DEAD_BAND:   dead_band_reg   <= cfg_data[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::REG_DRIVE_UPPER: drive_upper_reg <= cfg_data;
                ipid_pkg::REG_DRIVE_LOWER: drive_lower_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // error, dead zone and gain products
    ipid_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .target         (target),
        .measured_value (measured_value),
        .kp_gain        (kp_gain_reg),
        .ki_gain        (ki_gain_reg),
        .kd_gain        (kd_gain_reg),
        .dead_band      (dead_band_reg),
        .mid_valid      (mid_valid),
        .mid_ready      (mid_ready),
        .mid_ctl        (mid_ctl),
        .term_p         (term_p),
        .term_i         (term_i),
        .term_d         (term_d)
    );

    // accumulate, clamp and deliver
    ipid_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mid_valid   (mid_valid),
        .mid_ready   (mid_ready),
        .mid_ctl     (mid_ctl),
        .term_p      (term_p),
        .term_i      (term_i),
        .term_d      (term_d),
        .drive_upper (drive_upper_reg),
        .drive_lower (drive_lower_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .held        (held)
    );

endmodule

`default_nettype wire

/* hdl/ipid_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipid_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [ipid_pkg::DRIVE_W-1:0] drive,
    input  wire logic                                held
);

    logic [2:0]                          flight_reg;
    logic [2:0]                          flight_next;
    logic signed [ipid_pkg::DRIVE_W-1:0] last_drive_reg;
    logic                                in_acc;
    logic                                out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // transactions accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg;
        if (in_acc && !out_acc)
        begin
            flight_next = flight_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            flight_next = flight_reg - 3'd1;
        end
    end

    // last delivered drive value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg     <= '0;
            last_drive_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
            if (out_acc)
            begin
                last_drive_reg <= drive;
            end
        end
    end

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(held))
        else $error("result changed while stalled");

    // a dead zone result repeats the last delivered drive
    a_held_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && held |-> drive == last_drive_reg)
        else $error("held result differs from previous drive");

    // no result without an accepted transaction behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flight_reg != 3'd0)
        else $error("result without a pending transaction");

    // at most three transactions inside the pipeline
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= 3'd3)
        else $error("pipeline holds too many transactions");

endmodule

bind incremental_pid_deadzone ipid_checker u_ipid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .held      (held)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    // transaction codes and spare register indexes
    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;
    localparam logic [ipid_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ipid_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int FRAC        = ipid_pkg::FRAC_BITS_DEF;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 60000;

    typedef struct {
        logic                             func;
        logic signed [ipid_pkg::IN_W-1:0] target;
        logic signed [ipid_pkg::IN_W-1:0] meas;
    } pid_sample_t;

    typedef struct {
        logic signed [ipid_pkg::DRIVE_W-1:0] drive;
        logic                                held;
    } drive_res_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [ipid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ipid_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic signed [ipid_pkg::IN_W-1:0] target = '0;
    logic signed [ipid_pkg::IN_W-1:0] measured_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [ipid_pkg::DRIVE_W-1:0] drive;
    logic held;

    incremental_pid_deadzone u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .target         (target),
        .measured_value (measured_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .held           (held)
    );

    // pending samples and expected drive results
    pid_sample_t sample_q[$];
    drive_res_t  drive_exp_q[$];

    // regulator copy: gains, band, limits and history
    longint kp_q = ipid_pkg::KP_RESET;
    longint ki_q = ipid_pkg::KI_RESET;
    longint kd_q = ipid_pkg::KD_RESET;
    longint band_q = ipid_pkg::BAND_RESET;
    longint upper_q = ipid_pkg::UPPER_RESET;
    longint lower_q = ipid_pkg::LOWER_RESET;
    longint err1 = 0;
    longint err2 = 0;
    longint drive_lvl = 0;

    int  mismatch_cnt = 0;
    int  cycle_cnt = 0;
    int  send_idle_pct = 10;
    int  recv_idle_pct = 10;
    int  hold_req_cnt = 0;
    bit  taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // one velocity-form step with dead zone and upper-first clamp, or a clear
    function automatic drive_res_t pid_predict(pid_sample_t s);
        longint e;
        longint mag;
        longint delta;
        longint sum;
        drive_res_t r;
        if (s.func == FUNC_CLEAR)
        begin
            err1 = 0;
            err2 = 0;
            drive_lvl = 0;
            r.drive = '0;
            r.held = 1'b0;
            return r;
        end
        e = longint'(s.target) - longint'(s.meas);
        mag = (e < 0) ? -e : e;
        if (mag < band_q)
        begin
            r.drive = drive_lvl[ipid_pkg::DRIVE_W-1:0];
            r.held = 1'b1;
            return r;
        end
        delta = ((kp_q * (e - err1)) >>> FRAC) + ((ki_q * e) >>> FRAC)
              + ((kd_q * (e - 2 * err1 + err2)) >>> FRAC);
        sum = drive_lvl + delta;
        if (sum > upper_q)
            sum = upper_q;
        else if (sum < lower_q)
            sum = lower_q;
        drive_lvl = sum;
        err2 = err1;
        err1 = e;
        r.drive = sum[ipid_pkg::DRIVE_W-1:0];
        r.held = 1'b0;
        return r;
    endfunction

    // register write, applied to the regulator copy as well
    task automatic write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                             logic [ipid_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ipid_pkg::REG_KP_GAIN:     kp_q = val[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_KI_GAIN:     ki_q = val[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_KD_GAIN:     kd_q = val[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_DEAD_BAND:   band_q = val[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_DRIVE_UPPER:
                upper_q = longint'($signed(val[ipid_pkg::DRIVE_W-1:0]));
            ipid_pkg::REG_DRIVE_LOWER:
                lower_q = longint'($signed(val[ipid_pkg::DRIVE_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic write_all(int kp, int ki, int kd, int band, int upper, int lower);
        write_reg(ipid_pkg::REG_KP_GAIN, ipid_pkg::CFG_W'(kp));
        write_reg(ipid_pkg::REG_KI_GAIN, ipid_pkg::CFG_W'(ki));
        write_reg(ipid_pkg::REG_KD_GAIN, ipid_pkg::CFG_W'(kd));
        write_reg(ipid_pkg::REG_DEAD_BAND, ipid_pkg::CFG_W'(band));
        write_reg(ipid_pkg::REG_DRIVE_UPPER, ipid_pkg::CFG_W'(upper));
        write_reg(ipid_pkg::REG_DRIVE_LOWER, ipid_pkg::CFG_W'(lower));
    endtask

    task automatic push_sample(logic f, int t, int m);
        pid_sample_t s;
        s.func = f;
        s.target = t[ipid_pkg::IN_W-1:0];
        s.meas = m[ipid_pkg::IN_W-1:0];
        sample_q.push_back(s);
    endtask

    // wait until every sample is taken and every result is back
    task automatic wait_idle();
        while (sample_q.size() != 0 || drive_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly tracking samples near the setpoint, some wild and some clears
    task automatic push_random(int n, int span, int spread);
        int pick;
        int t;
        int m;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            t = int'($urandom_range(0, 2 * span)) - span;
            m = t + int'($urandom_range(0, 2 * spread)) - spread;
            if (m > 32767)
                m = 32767;
            if (m < -32768)
                m = -32768;
            if (pick < 5)
                push_sample(FUNC_CLEAR, $urandom(), $urandom());
            else if (pick < 35)
                push_sample(FUNC_STEP, $urandom(), $urandom());
            else if (pick < 45)
                push_sample(FUNC_STEP, t, t);
            else
                push_sample(FUNC_STEP, t, m);
        end
    endtask

    // sender: offer the oldest pending sample, hold it while stalled
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !taken)
            in_valid <= 1'b1;
        else if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            in_valid       <= 1'b1;
            func           <= sample_q[0].func;
            target         <= sample_q[0].target;
            measured_value <= sample_q[0].meas;
        end
        else
            in_valid <= 1'b0;
    end

    // accepted sample: predict its result
    always @(posedge clk)
    begin
        taken = rst_n && in_valid && !in_stall;
        if (taken)
        begin
            drive_exp_q.push_back(pid_predict(sample_q[0]));
            void'(sample_q.pop_front());
        end
    end

    // receiver: random stalls and long hold-offs on request
    always @(negedge clk)
    begin : recv_stall
        int hold_left;
        int hold_served;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            hold_served = 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_served < hold_req_cnt)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin : drive_monitor
        drive_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_exp_q.size() == 0)
                report_mismatch("unexpected result, drive", drive, 0);
            else
            begin
                want = drive_exp_q.pop_front();
                if (drive !== want.drive)
                    report_mismatch("drive", drive, want.drive);
                if (held !== want.held)
                    report_mismatch("held", held, want.held);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        // reset settings: clear, dead zone edges, extremes
        push_sample(FUNC_CLEAR, 0, 0);
        push_sample(FUNC_STEP, 1000, 1000);
        push_sample(FUNC_STEP, 25, 0);
        push_sample(FUNC_STEP, 0, 25);
        push_sample(FUNC_STEP, 26, 0);
        push_sample(FUNC_STEP, 0, 26);
        push_sample(FUNC_STEP, 32767, -32768);
        push_sample(FUNC_STEP, -32768, 32767);
        push_sample(FUNC_STEP, 512, 256);
        push_sample(FUNC_CLEAR, -1, 12345);
        wait_idle();

        // spare indexes are ignored
        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'h123456);
        push_sample(FUNC_STEP, 3000, 100);
        push_sample(FUNC_STEP, 100, 3000);
        wait_idle();

        // crossed limits: upper tested first
        write_reg(ipid_pkg::REG_DRIVE_UPPER, ipid_pkg::CFG_W'(-2560));
        write_reg(ipid_pkg::REG_DRIVE_LOWER, ipid_pkg::CFG_W'(2560));
        push_sample(FUNC_STEP, 20000, 0);
        push_sample(FUNC_STEP, -20000, 0);
        push_sample(FUNC_CLEAR, 7, 7);
        push_sample(FUNC_STEP, 40, 0);
        wait_idle();

        // largest gains, no dead zone, widest limits
        write_all(65535, 65535, 65535, 0, 24'h7FFFFF, 24'h800000);
        push_sample(FUNC_STEP, 0, 0);
        push_sample(FUNC_STEP, 32767, -32768);
        push_sample(FUNC_STEP, -32768, 32767);
        push_sample(FUNC_STEP, 32767, -32768);
        wait_idle();

        // zero gains, widest dead zone
        write_all(0, 0, 0, 65535, 24'h7FFFFF, 24'h800000);
        push_sample(FUNC_STEP, 32767, -32768);
        push_sample(FUNC_STEP, -32768, 32766);
        push_sample(FUNC_STEP, 100, -100);
        wait_idle();

        // random: reset values again, full range
        write_all(ipid_pkg::KP_RESET, ipid_pkg::KI_RESET, ipid_pkg::KD_RESET,
                  ipid_pkg::BAND_RESET, ipid_pkg::UPPER_RESET, ipid_pkg::LOWER_RESET);
        push_random(110, 32767, 4000);
        wait_idle();

        // random: gentle loop, long receiver hold-off, then a sender pause
        write_all(256, 16, 64, 4, 100000, -100000);
        push_random(55, 400, 60);
        hold_req_cnt++;
        wait_idle();
        push_random(55, 400, 60);
        wait_idle();

        // random: arbitrary settings, limits may cross
        write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 300),
                  $urandom(), $urandom());
        push_random(110, 32767, 2000);
        wait_idle();

        // random: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all($urandom_range(0, 2048), $urandom_range(0, 512),
                  $urandom_range(0, 2048), $urandom_range(0, 64),
                  500000, -500000);
        push_random(110, 2000, 200);
        wait_idle();
        send_idle_pct = 10;
        recv_idle_pct = 10;

        // random: largest gains, no dead zone
        write_all(65535, 65535, 65535, 0, 24'h7FFFFF, 24'h800000);
        push_random(110, 32767, 30000);
        wait_idle();

        if (drive_exp_q.size() != 0)
            report_mismatch("results missing", 0, drive_exp_q.size());
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
